/* design/smhp_pkg.sv */
// Shared types, constants and helpers for the message header parser.
// Used by the result channel interface, the check logic and the top level.
package smhp_pkg;

	// Message layout.
	localparam int PREFIX_BYTES   = 3;
	localparam int SEQUENCE_BYTES = 6;
	localparam int MIN_TAG_ROOM   = 4;
	localparam int MIN_MESSAGE    = PREFIX_BYTES + 1 + SEQUENCE_BYTES + MIN_TAG_ROOM;
	localparam int SEQ_W          = SEQUENCE_BYTES * 8;

	// Suite table.
	localparam int SUITE_ENTRIES  = 4;
	localparam int SUITE_ENTRY_W  = 16;
	localparam int SUITE_TABLE_W  = 64;

	// Byte counter width and the width used for length arithmetic.
	localparam int LENGTH_BITS    = 16;
	localparam int CALC_W         = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;

	// Configuration port.
	localparam int CFG_INDEX_W    = 3;
	localparam int CFG_DATA_W     = 64;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_EXPECTED_VERSION = 3'd0,
		CFG_UNUSED_KEY_MARKER = 3'd1,
		CFG_MAX_KEY_ID_LENGTH = 3'd2,
		CFG_MAX_MESSAGE_LENGTH = 3'd3,
		CFG_MAX_SEQUENCE_NUMBER = 3'd4,
		CFG_SUITE_TABLE = 3'd5
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_BAD_FORMAT    = 3'd1,
		ST_UNKNOWN_SUITE = 3'd2,
		ST_BAD_SIZE      = 3'd3,
		ST_SEQ_RANGE     = 3'd4
	} status_t;

	typedef logic [LENGTH_BITS-1:0] count_t;

	// Configuration register contents.
	typedef struct packed {
		logic [14:0]              expected_version;
		logic [7:0]               unused_key_marker;
		logic [7:0]               max_key_id_length;
		logic [15:0]              max_message_length;
		logic [SEQ_W-1:0]         max_sequence_number;
		logic [SUITE_TABLE_W-1:0] suite_table;
	} cfg_t;

	// Per-message parse state after the last item has been folded in.
	typedef struct packed {
		count_t           byte_count;
		logic             length_overflow;
		logic [15:0]      header_word;
		logic [7:0]       suite_byte;
		logic [7:0]       key_first_byte;
		logic [SEQ_W-1:0] sequence_shift;
	} msg_state_t;

	// One result item.
	typedef struct packed {
		status_t          status;
		logic             external_key_flag;
		logic [14:0]      version;
		logic [7:0]       suite_code;
		logic             has_key_id;
		logic [7:0]       key_id_length;
		logic [SEQ_W-1:0] sequence_number;
		logic [15:0]      payload_start;
		logic [15:0]      payload_length;
		logic [3:0]       tag_length;
	} result_t;

	// Bytes taken by the key identifier, given its first byte.
	function automatic logic [7:0] key_len(input logic [7:0] first, input logic [7:0] marker);
		logic [7:0] len;
		if (first == marker || !first[7]) begin
			len = 8'd1;
		end else begin
			len = 8'd1 + {1'b0, first[6:0]};
		end
		return len;
	endfunction

endpackage

/* design/smhp_msg_if.sv */
// Message byte channel: one byte and its last-byte mark per item.
// Depends on nothing outside this file.
interface smhp_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* design/smhp_res_if.sv */
// Result channel: one parsed header summary per item.
// Depends on smhp_pkg for the sequence number width.
interface smhp_res_if
	import smhp_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [2:0]       status;
	logic             external_key_flag;
	logic [14:0]      version;
	logic [7:0]       suite_code;
	logic             has_key_id;
	logic [7:0]       key_id_length;
	logic [SEQ_W-1:0] sequence_number;
	logic [15:0]      payload_start;
	logic [15:0]      payload_length;
	logic [3:0]       tag_length;

	modport source (output valid, output status, output external_key_flag, output version,
		output suite_code, output has_key_id, output key_id_length,
		output sequence_number, output payload_start, output payload_length,
		output tag_length, input ready);
	modport sink (input valid, input status, input external_key_flag, input version,
		input suite_code, input has_key_id, input key_id_length,
		input sequence_number, input payload_start, input payload_length,
		input tag_length, output ready);
endinterface

/* design/smhp_check.sv */
// End-of-message checks: status priority, suite lookup and length fields.
// Purely combinational; depends on smhp_pkg.
module smhp_check
	import smhp_pkg::*;
(
	input  msg_state_t st,
	input  cfg_t       cfg,
	output result_t    res
);

	logic [CALC_W-1:0]        n;
	logic [CALC_W-1:0]        poff;
	logic [CALC_W-1:0]        key_end;
	logic [7:0]               klen;
	logic                     multi_key;
	logic                     found;
	logic [3:0]               tag;
	logic [SUITE_ENTRY_W-1:0] ent;
	status_t                  status;

	assign n         = CALC_W'(st.byte_count);
	assign klen      = key_len(st.key_first_byte, cfg.unused_key_marker);
	assign multi_key = (st.key_first_byte != cfg.unused_key_marker) && st.key_first_byte[7];
	assign key_end   = CALC_W'(PREFIX_BYTES) + CALC_W'(klen);
	assign poff      = key_end + CALC_W'(SEQUENCE_BYTES);

	// Suite lookup: lowest valid entry with a matching code wins.
	always_comb begin
		found = 1'b0;
		tag   = '0;
		ent   = '0;
		for (int e = 0; e < SUITE_ENTRIES; e++) begin
			ent = cfg.suite_table[SUITE_ENTRY_W*e +: SUITE_ENTRY_W];
			if (!found && ent[15] && ent[7:0] == st.suite_byte) begin
				found = 1'b1;
				tag   = ent[11:8];
			end
		end
	end

	// Checks in priority order; the first failure sets the status.
	always_comb begin
		if (st.length_overflow || n > CALC_W'(cfg.max_message_length)
				|| n < CALC_W'(MIN_MESSAGE)) begin
			status = ST_BAD_SIZE;
		end else if (st.header_word[14:0] != cfg.expected_version) begin
			status = ST_BAD_FORMAT;
		end else if (!found) begin
			status = ST_UNKNOWN_SUITE;
		end else if (multi_key && (klen < 8'd2 || klen > cfg.max_key_id_length)) begin
			status = ST_BAD_FORMAT;
		end else if (multi_key && key_end > n) begin
			status = ST_BAD_SIZE;
		end else if (poff > n || (n - poff) < CALC_W'(tag)) begin
			status = ST_BAD_SIZE;
		end else if (st.sequence_shift > cfg.max_sequence_number) begin
			status = ST_SEQ_RANGE;
		end else begin
			status = ST_OK;
		end
	end

	// All fields but the status read zero on an error.
	always_comb begin
		res        = '0;
		res.status = status;
		if (status == ST_OK) begin
			res.external_key_flag = st.header_word[15];
			res.version           = st.header_word[14:0];
			res.suite_code        = st.suite_byte;
			res.has_key_id        = (st.key_first_byte != cfg.unused_key_marker);
			res.key_id_length     = klen;
			res.sequence_number   = st.sequence_shift;
			res.payload_start     = poff[15:0];
			res.payload_length    = 16'(n - poff - CALC_W'(tag));
			res.tag_length        = tag;
		end
	end

endmodule

/* design/secure_message_header_parser.sv */
// Streaming header parser for protected messages, one byte per item.
// The last byte of a message passes the input register, then the result register is loaded and valid.
// Throughput: one byte per cycle while results are taken; while a result waits,
// one more byte enters the input register and the input then stalls until it is taken.
// Reset (arst_n, asynchronous): per-message state, valid flags and the
// configuration registers return to their defaults; no clearing pass is needed.
module secure_message_header_parser
	import smhp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	smhp_msg_if.sink               msg,
	smhp_res_if.source             result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam count_t COUNT_MAX = '1;

	cfg_t       cfg_q;
	msg_state_t state_q;
	msg_state_t state_n;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       stall;
	logic       fire_s1;
	logic       res_valid_q;
	result_t    res_q;
	result_t    res_c;
	logic [8:0] seq_start;
	logic       in_seq;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version    <= '0;
			cfg_q.unused_key_marker   <= 8'd128;
			cfg_q.max_key_id_length   <= 8'd8;
			cfg_q.max_message_length  <= 16'd2048;
			cfg_q.max_sequence_number <= '1;
			cfg_q.suite_table         <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXPECTED_VERSION:    cfg_q.expected_version    <= cfg_wdata[14:0];
				CFG_UNUSED_KEY_MARKER:   cfg_q.unused_key_marker   <= cfg_wdata[7:0];
				CFG_MAX_KEY_ID_LENGTH:   cfg_q.max_key_id_length   <= cfg_wdata[7:0];
				CFG_MAX_MESSAGE_LENGTH:  cfg_q.max_message_length  <= cfg_wdata[15:0];
				CFG_MAX_SEQUENCE_NUMBER: cfg_q.max_sequence_number <= cfg_wdata[SEQ_W-1:0];
				CFG_SUITE_TABLE:         cfg_q.suite_table <= cfg_wdata[SUITE_TABLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the input stage holds only while a result waits and cannot drain.
	assign stall     = res_valid_q && !result.ready;
	assign msg.ready = !(valid_s1 && stall);
	assign fire_s1   = valid_s1 && !stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.ready) begin
			byte_s1 <= msg.data_byte;
			last_s1 <= msg.last_byte;
		end
	end

	// Sequence number window follows the key identifier.
	assign seq_start = 9'(PREFIX_BYTES) + 9'(key_len(state_q.key_first_byte,
		cfg_q.unused_key_marker));
	assign in_seq = (CALC_W'(state_q.byte_count) >= CALC_W'(seq_start))
		&& (CALC_W'(state_q.byte_count) < CALC_W'(seq_start) + CALC_W'(SEQUENCE_BYTES));

	// Fold the current byte into the per-message state.
	always_comb begin
		state_n = state_q;
		case (state_q.byte_count)
			count_t'(0): state_n.header_word[15:8] = byte_s1;
			count_t'(1): state_n.header_word[7:0]  = byte_s1;
			count_t'(2): state_n.suite_byte        = byte_s1;
			count_t'(PREFIX_BYTES): state_n.key_first_byte = byte_s1;
			default: begin
				if (in_seq) begin
					state_n.sequence_shift = {state_q.sequence_shift[SEQ_W-9:0], byte_s1};
				end
			end
		endcase
		if (state_q.byte_count == COUNT_MAX) begin
			state_n.length_overflow = 1'b1;
		end else begin
			state_n.byte_count = state_q.byte_count + count_t'(1);
		end
	end

	smhp_check u_check (
		.st  (state_n),
		.cfg (cfg_q),
		.res (res_c)
	);

	// Per-message state; cleared after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				state_q <= '0;
			end else begin
				state_q <= state_n;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			res_q <= res_c;
		end
	end

	// Result channel outputs.
	assign result.valid             = res_valid_q;
	assign result.status            = res_q.status;
	assign result.external_key_flag = res_q.external_key_flag;
	assign result.version           = res_q.version;
	assign result.suite_code        = res_q.suite_code;
	assign result.has_key_id        = res_q.has_key_id;
	assign result.key_id_length     = res_q.key_id_length;
	assign result.sequence_number   = res_q.sequence_number;
	assign result.payload_start     = res_q.payload_start;
	assign result.payload_length    = res_q.payload_length;
	assign result.tag_length        = res_q.tag_length;

endmodule
